### design/modular_exponentiation_core_assert.svh
// ----------------------------------------------------------------------------
// modular_exponentiation_core_assert.svh
// assertion macros shared by the modular exponentiation core modules
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_CORE_ASSERT_SVH
`define MODULAR_EXPONENTIATION_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define MEXP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define MEXP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define MEXP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MEXP_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

### design/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// types and constants shared by the modular exponentiation core
// ----------------------------------------------------------------------------
package mexp_pkg;

    // operand width scanned by the multiply unit (base width)
    localparam int OP_W  = 32;
    // counter width, holds OP_W itself
    localparam int CNT_W = 6;
    // result and configuration width
    localparam int OUT_W = 31;

    // modulus after reset
    localparam logic [OUT_W-1:0] MODULUS_RESET = 31'd1000000007;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_MUL,
        ST_FINISH
    } mexp_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_item;
        logic start_reduce;
        logic take_reduce;
        logic start_step;
        logic take_step;
        logic load_out;
    } mexp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic mod_small;
        logic units_idle;
        logic base_zero;
        logic exp_zero;
    } mexp_status_t;

endpackage

### design/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// mexp_mulmod
// bit-serial interleaved modular multiplier: r = a * x mod m, one bit of x
// per cycle, msb first; requires a < m
// ----------------------------------------------------------------------------
`include "modular_exponentiation_core_assert.svh"

module mexp_mulmod #(
    parameter int MOD_BITS = 31
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [MOD_BITS-1:0]          a_in,
    input  logic [mexp_pkg::OP_W-1:0]    x_in,
    input  logic [mexp_pkg::CNT_W-1:0]   len_in,
    input  logic [MOD_BITS-1:0]          m_in,
    output logic                         busy,
    output logic [MOD_BITS-1:0]          r
);
    import mexp_pkg::*;

    logic [MOD_BITS-1:0] r_reg, r_next;
    logic [MOD_BITS-1:0] a_reg;
    logic [MOD_BITS-1:0] m_reg;
    logic [OP_W-1:0]     x_reg, x_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic [MOD_BITS:0] dbl;
    logic [MOD_BITS:0] dbl_red;
    logic [MOD_BITS:0] sum;
    logic [MOD_BITS:0] m_ext;

    assign m_ext = {1'b0, m_reg};

    // one step: double, reduce, add a if bit set, reduce
    always_comb
    begin
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
        sum     = dbl_red + (x_reg[OP_W-1] ? {1'b0, a_reg} : {(MOD_BITS+1){1'b0}});
        r_next  = (sum >= m_ext) ? MOD_BITS'(sum - m_ext) : MOD_BITS'(sum);
        x_next  = {x_reg[OP_W-2:0], 1'b0};
        cnt_next = cnt_reg - CNT_W'(1);
    end

    // iteration counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= len_in;
        end
        else if (busy)
        begin
            cnt_reg <= cnt_next;
        end
    end

    // operand and partial result registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg <= '0;
            a_reg <= a_in;
            m_reg <= m_in;
            x_reg <= x_in;
        end
        else if (busy)
        begin
            r_reg <= r_next;
            x_reg <= x_next;
        end
    end

    assign busy = (cnt_reg != '0);
    assign r    = r_reg;

    // assertions
    `MEXP_ASSERT_NXT(a_start_busy, clk, rst_n, start && (len_in != '0), busy)
    `MEXP_ASSERT_IMP(a_result_reduced, clk, rst_n, $fell(busy), r_reg < m_reg)

endmodule

### design/mexp_datapath.sv
// ----------------------------------------------------------------------------
// mexp_datapath
// modulus register, running base, accumulator, exponent shifter, two
// serial modular multipliers (multiply and square) and result register
// ----------------------------------------------------------------------------
module mexp_datapath #(
    parameter int EXP_BITS = 32,
    parameter int MOD_BITS = 31
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mexp_pkg::mexp_cmd_t           cmd,
    output mexp_pkg::mexp_status_t        status,
    input  logic                          cfg_wr_en,
    input  logic [mexp_pkg::OUT_W-1:0]    cfg_wr_data,
    input  logic [mexp_pkg::OP_W-1:0]     base_value,
    input  logic [31:0]                   exponent_value,
    output logic [mexp_pkg::OUT_W-1:0]    power_result
);
    import mexp_pkg::*;

    localparam int PAD_W = OP_W - MOD_BITS;

    logic [MOD_BITS-1:0] modulus_reg;
    logic [MOD_BITS-1:0] acc_reg;
    logic [MOD_BITS-1:0] b_reg;
    logic [EXP_BITS-1:0] exp_reg;
    logic [OUT_W-1:0]    result_reg;

    logic [MOD_BITS-1:0] mul_a, sq_a;
    logic [OP_W-1:0]     mul_x, sq_x;
    logic [CNT_W-1:0]    mul_len, sq_len;
    logic                mul_start;
    logic                mul_busy, sq_busy;
    logic [MOD_BITS-1:0] mul_r, sq_r;

    // modulus configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET[MOD_BITS-1:0];
        end
        else if (cfg_wr_en)
        begin
            modulus_reg <= cfg_wr_data[MOD_BITS-1:0];
        end
    end

    // multiplier operands: base reduction shares the multiply unit
    always_comb
    begin
        if (cmd.start_reduce)
        begin
            mul_a   = MOD_BITS'(1);
            mul_x   = base_value;
            mul_len = CNT_W'(OP_W);
        end
        else
        begin
            mul_a   = acc_reg;
            mul_x   = {b_reg, {PAD_W{1'b0}}};
            mul_len = CNT_W'(MOD_BITS);
        end
        sq_a   = b_reg;
        sq_x   = {b_reg, {PAD_W{1'b0}}};
        sq_len = CNT_W'(MOD_BITS);
    end

    assign mul_start = cmd.start_reduce | cmd.start_step;

    mexp_mulmod #(
        .MOD_BITS (MOD_BITS)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a_in   (mul_a),
        .x_in   (mul_x),
        .len_in (mul_len),
        .m_in   (modulus_reg),
        .busy   (mul_busy),
        .r      (mul_r)
    );

    mexp_mulmod #(
        .MOD_BITS (MOD_BITS)
    ) u_sq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.start_step),
        .a_in   (sq_a),
        .x_in   (sq_x),
        .len_in (sq_len),
        .m_in   (modulus_reg),
        .busy   (sq_busy),
        .r      (sq_r)
    );

    // accumulator, running base and exponent
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            acc_reg <= '0;
            exp_reg <= EXP_BITS'(exponent_value);
        end
        else if (cmd.take_reduce)
        begin
            acc_reg <= (mul_r == '0) ? '0 : MOD_BITS'(1);
            b_reg   <= mul_r;
        end
        else if (cmd.take_step)
        begin
            if (exp_reg[0])
            begin
                acc_reg <= mul_r;
            end
            b_reg   <= sq_r;
            exp_reg <= exp_reg >> 1;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            result_reg <= OUT_W'(acc_reg);
        end
    end

    assign power_result = result_reg;

    // status to controller
    always_comb
    begin
        status.mod_small  = (modulus_reg <= MOD_BITS'(1));
        status.units_idle = !mul_busy && !sq_busy;
        status.base_zero  = (mul_r == '0);
        status.exp_zero   = (exp_reg == '0);
    end

endmodule

### design/mexp_ctrl.sv
// ----------------------------------------------------------------------------
// mexp_ctrl
// sequencer for reduction, per-bit square and multiply steps and the
// output request register
// ----------------------------------------------------------------------------
`include "modular_exponentiation_core_assert.svh"

module mexp_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    output logic                     out_valid,
    input  logic                     out_stall,
    output mexp_pkg::mexp_cmd_t      cmd,
    input  mexp_pkg::mexp_status_t   status
);
    import mexp_pkg::*;

    mexp_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // state register and output request flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.mod_small ? ST_FINISH : ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (status.units_idle)
                begin
                    state_next = status.base_zero ? ST_FINISH : ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = status.exp_zero ? ST_FINISH : ST_MUL;
            end
            ST_MUL:
            begin
                if (status.units_idle)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // commands and handshake outputs
    always_comb
    begin
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load_item    = in_valid;
                cmd.start_reduce = in_valid && !status.mod_small;
            end
            ST_REDUCE:
            begin
                cmd.take_reduce = status.units_idle;
            end
            ST_CHECK:
            begin
                cmd.start_step = !status.exp_zero;
            end
            ST_MUL:
            begin
                cmd.take_step = status.units_idle;
            end
            ST_FINISH:
            begin
                cmd.load_out = out_free;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    // assertions
    `MEXP_ASSERT_NXT(a_small_mod_finish, clk, rst_n, in_valid && !in_stall && status.mod_small, state_reg == ST_FINISH)
    `MEXP_ASSERT_NXT(a_finish_holds, clk, rst_n, (state_reg == ST_FINISH) && out_valid_reg && out_stall, (state_reg == ST_FINISH) && out_valid_reg)

endmodule

### design/modular_exponentiation_core.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// base ** exponent mod modulus by right-to-left square and multiply
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------
//  in       | in_valid / in_stall    | base_value, exponent_value
//  out      | out_valid / out_stall  | power_result
//  cfg      | cfg_wr_en              | cfg_wr_data (modulus)
//
//  one request at a time; base reduction runs in the shared serial
//  multiplier, then each exponent bit up to the highest set one takes a
//  step in which multiply and square run side by side, and a last
//  exponent check and the result load close the request
//  modulus of zero or one, and a base that reduces to zero, finish early
//  reset loads the modulus 1000000007; no clearing pass
//  a finished result waits in the output register while out_stall is high;
//  the next request is taken once the result is registered
// ----------------------------------------------------------------------------
module modular_exponentiation_core #(
    parameter int EXP_BITS = 32,
    parameter int MOD_BITS = 31
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [mexp_pkg::OUT_W-1:0]    cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mexp_pkg::OP_W-1:0]     base_value,
    input  logic [31:0]                   exponent_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mexp_pkg::OUT_W-1:0]    power_result
);
    import mexp_pkg::*;

    mexp_cmd_t    cmd;
    mexp_status_t status;

    // sequencer
    mexp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    // arithmetic and storage
    mexp_datapath #(
        .EXP_BITS (EXP_BITS),
        .MOD_BITS (MOD_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .base_value     (base_value),
        .exponent_value (exponent_value),
        .power_result   (power_result)
    );

endmodule

### bench/tb_modular_exponentiation_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modular_exponentiation_core
// self-checking bench for the modular exponentiation core
//
// Requests of base and exponent are sent while the receiver stalls in
// random bursts. A ledger predicts base ** exponent mod modulus for each
// accepted request and checks every result against the oldest prediction.
// The modulus is rewritten between phases, only once the core has drained.
// ----------------------------------------------------------------------------

// predicted powers, in request order
class power_ledger;
    bit [mexp_pkg::OUT_W-1:0] modulus;
    bit [mexp_pkg::OUT_W-1:0] expected_powers[$];
    int                       mismatches;

    function new();
        modulus    = mexp_pkg::MODULUS_RESET;
        mismatches = 0;
    endfunction

    function void set_modulus(bit [mexp_pkg::OUT_W-1:0] value);
        modulus = value;
    endfunction

    function int pending();
        return expected_powers.size();
    endfunction

    // right-to-left square and multiply, all products below 2**62
    function bit [mexp_pkg::OUT_W-1:0] predict_power(bit [31:0] base, bit [31:0] expo);
        bit [63:0] m;
        bit [63:0] acc;
        bit [63:0] sq;
        int        i;
        m = modulus;
        if (m == 0)
            return '0;
        sq = base % m;
        // a base that reduces to zero gives zero, even for exponent zero
        if (sq == 0)
            return '0;
        acc = 64'd1 % m;
        for (i = 0; i < 32; i++)
        begin
            if (expo[i])
                acc = (acc * sq) % m;
            sq = (sq * sq) % m;
        end
        return acc[mexp_pkg::OUT_W-1:0];
    endfunction

    function void note_request(bit [31:0] base, bit [31:0] expo);
        expected_powers.push_back(predict_power(base, expo));
    endfunction

    task report_mismatch(string what);
        $display("ERROR at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    task check_result(bit [mexp_pkg::OUT_W-1:0] got);
        bit [mexp_pkg::OUT_W-1:0] want;
        if (expected_powers.size() == 0)
        begin
            report_mismatch($sformatf("unexpected power_result %0d", got));
            return;
        end
        want = expected_powers.pop_front();
        if (got !== want)
            report_mismatch($sformatf("power_result %0d, predicted %0d", got, want));
    endtask
endclass

module tb_modular_exponentiation_core;
    import mexp_pkg::*;

    localparam int          LIMIT_CYCLES = 5_000_000;
    localparam int          TAIL_CYCLES  = 40;
    localparam int          PHASE_ITEMS  = 100;
    localparam bit [30:0]   MOD_MAX      = 31'h7FFF_FFFF;

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               cfg_wr_en      = 1'b0;
    logic [OUT_W-1:0]   cfg_wr_data    = '0;
    logic               in_valid       = 1'b0;
    logic               in_stall;
    logic [OP_W-1:0]    base_value     = '0;
    logic [31:0]        exponent_value = '0;
    logic               out_valid;
    logic               out_stall      = 1'b0;
    logic [OUT_W-1:0]   power_result;

    power_ledger ledger = new();

    bit sender_gaps     = 1'b1;
    bit receiver_stalls = 1'b1;
    int stall_run       = 0;
    int cycle_count     = 0;

    modular_exponentiation_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .base_value     (base_value),
        .exponent_value (exponent_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .power_result   (power_result)
    );

    always #6 clk = ~clk;

    // receiver stalls in random bursts
    always @(posedge clk)
    begin
        if (stall_run == 0 && receiver_stalls && $urandom_range(0, 11) == 0)
            stall_run = $urandom_range(1, 19);
        if (stall_run > 0)
        begin
            out_stall <= 1'b1;
            stall_run--;
        end
        else
            out_stall <= 1'b0;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            ledger.check_result(power_result);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // one request, with an optional idle burst ahead of it
    task automatic send_request(input bit [31:0] base, input bit [31:0] expo);
        int gap;
        gap = 0;
        if (sender_gaps && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        base_value     <= base;
        exponent_value <= expo;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ledger.note_request(base, expo);
    endtask

    // hold off until every predicted power has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (ledger.pending() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_modulus(input bit [30:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        ledger.set_modulus(value);
    endtask

    // random request shaped by the current modulus
    task automatic random_request();
        bit [63:0] m;
        bit [63:0] mult;
        bit [31:0] base;
        bit [31:0] expo;
        int        pick;
        m    = ledger.modulus;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            base = $urandom;
        else if (pick < 7 && m > 1)
            base = $urandom_range(0, 32'(m - 1));
        else if (pick < 9)
            base = $urandom_range(0, 255);
        else if (m > 1)
        begin
            // multiple of the modulus, reduces to zero
            mult = m * $urandom_range(0, 32'(64'h0000_0000_FFFF_FFFF / m));
            base = mult[31:0];
        end
        else
            base = $urandom;
        // mostly short exponents, full width now and then
        if ($urandom_range(0, 4) == 0)
            expo = $urandom;
        else
            expo = $urandom & ((32'd1 << $urandom_range(0, 8)) - 32'd1);
        send_request(base, expo);
    endtask

    initial
    begin
        bit [30:0] phase_mod[8];
        int        p;
        int        n;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset modulus: zero, one and full-width operands
        send_request(32'd0, 32'd0);
        send_request(32'd0, 32'hFFFF_FFFF);
        send_request(32'd1, 32'd0);
        send_request(32'd12345, 32'd1);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'd1);
        send_request(32'd1000000007, 32'd5);
        send_request(32'd2000000014, 32'd0);
        send_request(32'd1000000006, 32'd2);
        send_request(32'd2, 32'd31);
        send_request(32'd3, 32'h8000_0000);

        // modulus of one: every base reduces to zero
        wait_drained();
        write_modulus(31'd1);
        send_request(32'd7, 32'd0);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // zero modulus
        wait_drained();
        write_modulus(31'd0);
        send_request(32'd5, 32'd0);
        send_request(32'hFFFF_FFFF, 32'd3);

        // largest modulus
        wait_drained();
        write_modulus(MOD_MAX);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'h7FFF_FFFE, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFE, 32'd0);
        send_request(32'h7FFF_FFFF, 32'd0);

        // random phases, each with its own modulus
        phase_mod[0] = 31'd2;
        phase_mod[1] = 31'($urandom_range(2, 1000));
        phase_mod[2] = MOD_MAX;
        phase_mod[3] = 31'($urandom_range(1, 32'(MOD_MAX)));
        phase_mod[4] = 31'd0;
        phase_mod[5] = 31'd3;
        phase_mod[6] = 31'($urandom_range(32'h4000_0000, 32'(MOD_MAX)));
        phase_mod[7] = MODULUS_RESET;
        for (p = 0; p < 8; p++)
        begin
            wait_drained();
            write_modulus(phase_mod[p]);
            // last phase runs at full rate
            if (p == 7)
            begin
                sender_gaps     = 1'b0;
                receiver_stalls = 1'b0;
            end
            for (n = 0; n < PHASE_ITEMS; n++)
                random_request();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (ledger.mismatches == 0 && ledger.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
